// ===== hdl/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
// Used by swm_cell and sliding_window_median; no dependencies.
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int AGE_BITS    = $clog2(WINDOW_MAX);
  localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int WS_BITS     = 7;

  localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(3);

  // register index of window_size
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // one element of the sorted window
  typedef struct packed {
    logic                          valid;
    logic [AGE_BITS-1:0]           age;
    logic signed [SAMPLE_BITS-1:0] val;
  } cell_t;

  // per-cell decisions seen by the neighbors
  typedef struct packed {
    logic above_del;  // cell sits above the removed element
    logic above_new;  // cell holds a value above the new sample
    logic del;        // cell holds the oldest element, removed this step
  } flag_t;

  // broadcast to every cell
  typedef struct packed {
    logic                          step;
    logic                          clear;
    logic                          start;
    logic                          del_active;
    logic [AGE_BITS-1:0]           oldest_age;
    logic signed [SAMPLE_BITS-1:0] new_val;
    logic signed [SAMPLE_BITS-1:0] old_val;
  } bcast_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_median.sv =====
// Sliding-window lower-median filter: top level, stream and APB ports.
// The chain updates at the accepting edge; the median is then read from the middle rank into the output register.
// Throughput: one sample per cycle while m_tready holds; a median waiting in the
// output register with m_tready low stalls s_tready once a further result is pending.
// Reset (rst, synchronous): window empty, window_size = 3, no result pending.
// Depends on swm_pkg and swm_cell.
`default_nettype none

module sliding_window_median (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic        s_tuser,   // [0] start_of_stream
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] median
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int N  = swm_pkg::WINDOW_MAX;
  localparam int AB = swm_pkg::AGE_BITS;
  localparam int CB = swm_pkg::CNT_BITS;
  localparam int WB = swm_pkg::WS_BITS;
  localparam int SB = swm_pkg::SAMPLE_BITS;

  logic [WB-1:0] window_size;
  logic [CB-1:0] fill_count;
  logic [CB-1:0] count_eff;
  logic [CB-1:0] count_after;
  logic [CB-1:0] k;
  logic [AB-1:0] km1;
  logic [AB-1:0] mid;
  logic [AB-1:0] next_oldest_age;
  logic          use_new_as_oldest;
  logic signed [SB-1:0] old_val;
  logic signed [SB-1:0] old_val_next;
  logic          accept;
  logic          cfg_wr;
  logic          pend;
  logic          capture;
  logic          del_active;

  swm_pkg::bcast_t bc;
  swm_pkg::cell_t  st   [N];
  swm_pkg::flag_t  flg  [N];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == swm_pkg::REG_WINDOW_SIZE) begin
      prdata = 32'(window_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WS_RESET;
    end else if (cfg_wr) begin
      window_size <= pwdata[WB-1:0];
    end
  end

  // effective window size
  always_comb begin
    if (window_size == '0) begin
      k = CB'(1);
    end else if (CB'(window_size) > CB'(N)) begin
      k = CB'(N);
    end else begin
      k = CB'(window_size);
    end
    km1 = AB'(k - CB'(1));
    mid = km1 >> 1;
  end

  // handshake
  assign capture  = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // fill bookkeeping
  always_comb begin
    count_eff   = s_tuser ? '0 : fill_count;
    del_active  = (count_eff == k);
    count_after = del_active ? count_eff : count_eff + CB'(1);
    use_new_as_oldest = (count_after < CB'(2));
    next_oldest_age   = AB'(count_after - CB'(2));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= count_after;
    end
  end

  // oldest word for the next step: the cell that will be oldest after this one
  always_comb begin
    old_val_next = '0;
    for (int i = 0; i < N; i++) begin
      if (st[i].valid && !s_tuser && (st[i].age == next_oldest_age)) begin
        old_val_next = old_val_next | st[i].val;
      end
    end
    if (use_new_as_oldest) begin
      old_val_next = $signed(s_tdata[SB-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_val <= old_val_next;
    end
  end

  // broadcast to the chain
  always_comb begin
    bc.step       = accept;
    bc.clear      = cfg_wr;
    bc.start      = s_tuser;
    bc.del_active = del_active;
    bc.oldest_age = km1;
    bc.new_val    = $signed(s_tdata[SB-1:0]);
    bc.old_val    = old_val;
  end

  // the sorted cell chain
  for (genvar j = 0; j < N; j++) begin : g_cell
    swm_pkg::flag_t dn_f, up_f;
    swm_pkg::cell_t dn_s, up_s;
    if (j == 0) begin : g_lo
      assign dn_f = '{above_del: 1'b0, above_new: 1'b0, del: 1'b0};
      assign dn_s = '0;
    end else begin : g_lo
      assign dn_f = flg[j-1];
      assign dn_s = st[j-1];
    end
    if (j == N - 1) begin : g_hi
      assign up_f = '{above_del: 1'b1, above_new: 1'b1, del: 1'b0};
      assign up_s = '0;
    end else begin : g_hi
      assign up_f = flg[j+1];
      assign up_s = st[j+1];
    end
    swm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bc      (bc),
      .dn_flag (dn_f),
      .up_flag (up_f),
      .dn_st   (dn_s),
      .up_st   (up_s),
      .flag    (flg[j]),
      .st      (st[j])
    );
  end

  // result pending in the chain, read at the middle rank when the output register can take it
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pend <= 1'b0;
    end else if (accept && (count_after == k)) begin
      pend <= 1'b1;
    end else if (capture) begin
      pend <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (capture) begin
      m_tdata <= st[mid].val;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swm_cell.sv =====
// One cell of the sorted chain: holds one element, removes/inserts in step.
// Depends on swm_pkg.
`default_nettype none

module swm_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire swm_pkg::bcast_t bc,
  input  wire swm_pkg::flag_t  dn_flag,
  input  wire swm_pkg::flag_t  up_flag,
  input  wire swm_pkg::cell_t  dn_st,
  input  wire swm_pkg::cell_t  up_st,
  output swm_pkg::flag_t      flag,
  output swm_pkg::cell_t      st
);

  localparam logic [swm_pkg::AGE_BITS-1:0] AGE_ONE = swm_pkg::AGE_BITS'(1);

  swm_pkg::cell_t st_next;
  logic           valid_eff;

  // local decisions
  always_comb begin
    valid_eff      = st.valid && !bc.start;
    flag.del       = valid_eff && bc.del_active && (st.age == bc.oldest_age);
    flag.above_new = !valid_eff || (st.val > bc.new_val);
    if (valid_eff) begin
      flag.above_del = bc.del_active && !flag.del && (st.val >= bc.old_val);
    end else begin
      flag.above_del = bc.del_active;
    end
  end

  // pick the source of the new contents: self, upper, lower neighbor or new word
  always_comb begin
    if ((flag.above_del == flag.above_new) && !flag.del) begin
      st_next       = st;
      st_next.valid = valid_eff;
    end else if (up_flag.above_del && !up_flag.above_new) begin
      st_next       = up_st;
      st_next.valid = up_st.valid && !bc.start;
    end else if (!dn_flag.above_del && dn_flag.above_new && !dn_flag.del) begin
      st_next       = dn_st;
      st_next.valid = dn_st.valid && !bc.start;
    end else begin
      st_next.valid = 1'b1;
      st_next.age   = '0;
      st_next.val   = bc.new_val;
    end
  end

  // state update; every word that stays ages by one
  always_ff @(posedge clk) begin
    if (rst || bc.clear) begin
      st.valid <= 1'b0;
    end else if (bc.step) begin
      st.valid <= st_next.valid;
    end
    if (bc.step) begin
      st.val <= st_next.val;
      if ((flag.above_del == flag.above_new) && !flag.del) begin
        st.age <= st.age + AGE_ONE;
      end else if (up_flag.above_del && !up_flag.above_new) begin
        st.age <= up_st.age + AGE_ONE;
      end else if (!dn_flag.above_del && dn_flag.above_new && !dn_flag.del) begin
        st.age <= dn_st.age + AGE_ONE;
      end else begin
        st.age <= '0;
      end
    end
  end

endmodule

`default_nettype wire
